>>> src/matrix_multiply_top_defines.svh
// Assertion macros for the matrix multiply block.
// Included by the top level; no other dependencies.
`ifndef MATRIX_MULTIPLY_TOP_DEFINES_SVH
`define MATRIX_MULTIPLY_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define MM_ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define MM_ASSERT(label, prop, msg) \
   `MM_ASSERT_CLK(label, clock, reset, prop, msg)
`else
`define MM_ASSERT_CLK(label, clk, rst, prop, msg)
`define MM_ASSERT(label, prop, msg)
`endif
`endif

>>> src/mm_pkg.sv
// Shared types and constants for the matrix multiply block.
// No dependencies; used by the interfaces and by the top, sequencer and MAC modules.
package mm_pkg;

   localparam int MAX_DIM_DEFAULT = 16;
   localparam int CMD_W           = 2;
   localparam int INDEX_W         = 8;
   localparam int ELEM_W          = 16;
   localparam int PROD_W          = 32;
   localparam int ACC_W           = 40;
   localparam int CFG_W           = 5;
   localparam int CSR_ADDR_W      = 2;
   localparam int RSP_Q_DEPTH     = 3;

   localparam logic [CFG_W-1:0] DIM_RESET = 5'd16;

   typedef enum logic [CMD_W-1:0] {
      CMD_WRITE_A = 2'd0,
      CMD_WRITE_B = 2'd1,
      CMD_COMPUTE = 2'd2,
      CMD_READ    = 2'd3
   } cmd_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_RESULT_ROWS  = 2'd0,
      CSR_INNER_LENGTH = 2'd1,
      CSR_RESULT_COLS  = 2'd2
   } csr_index_type;

   typedef enum logic {
      SEQ_IDLE = 1'b0,
      SEQ_RUN  = 1'b1
   } seq_state_type;

   // Control traveling alongside one multiply-accumulate term.
   typedef struct packed {
      logic valid;
      logic first;
      logic last;
   } mac_ctl_type;

endpackage

>>> src/mm_req_if.sv
// Command channel interface for the matrix multiply block.
// Depends on mm_pkg for field widths.
interface mm_req_if;
   logic                              valid;
   logic                              ready;
   logic [mm_pkg::CMD_W-1:0]          cmd;
   logic [mm_pkg::INDEX_W-1:0]        element_index;
   logic signed [mm_pkg::ELEM_W-1:0]  element_value;

   modport source (output valid, cmd, element_index, element_value, input ready);
   modport sink   (input valid, cmd, element_index, element_value, output ready);
endinterface

>>> src/mm_rsp_if.sv
// Result channel interface for the matrix multiply block.
// Depends on mm_pkg for field widths.
interface mm_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [mm_pkg::ACC_W-1:0]   product_value;
   logic [mm_pkg::INDEX_W-1:0]        product_index;

   modport source (output valid, product_value, product_index, input ready);
   modport sink   (input valid, product_value, product_index, output ready);
endinterface

>>> src/mm_csr_if.sv
// Register write channel interface for the matrix multiply block.
// Depends on mm_pkg for field widths.
interface mm_csr_if;
   logic                              valid;
   logic                              ready;
   logic [mm_pkg::CSR_ADDR_W-1:0]     index;
   logic [mm_pkg::CFG_W-1:0]          data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

>>> src/matrix_multiply_top.sv
// Top level of the dense matrix multiply block.
// Depends on mm_pkg, the channel interfaces, mm_ram, mm_seq and mm_mac.
//
// Usage: A and B are loaded one element per command beat on req_if
// (cmd write A / write B, flat row-major index, signed Q8.8 value).
// A compute beat fills the product store with R = A x B in Q24.16.
// A read beat returns one product element and its index on rsp_if;
// it is the only command that produces a beat there.
// Dimensions come from three registers written over csr_if, which is
// always ready; write them only while the block is idle.
// Throughput: write and read beats are taken one per cycle while req_if.ready
// is high. A read result passes through the product RAM's registered read and
// then the result queue write before it can be taken. A compute beat occupies
// the block while the sequencer issues one A/B element pair per cycle from the
// two element RAMs, and then while the multiply, accumulate and write-back
// stages drain.
// Stall: results wait in a three-entry queue; req_if.ready drops only
// when the queue plus a read in flight would fill it, or while computing.
// Reset: dimensions return to 16, the sequencer and queue empty; the
// stores keep their contents and must be written before they are read.
`include "matrix_multiply_top_defines.svh"
module matrix_multiply_top #(
   parameter int MAX_DIM = mm_pkg::MAX_DIM_DEFAULT
) (
   input logic   clock,
   input logic   reset,
   mm_req_if.sink   req_if,
   mm_rsp_if.source rsp_if,
   mm_csr_if.sink   csr_if
);

   localparam int DEPTH  = MAX_DIM * MAX_DIM;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int DIM_W  = $clog2(MAX_DIM + 1);
   localparam int QP_W   = $clog2(mm_pkg::RSP_Q_DEPTH);
   localparam int QC_W   = $clog2(mm_pkg::RSP_Q_DEPTH + 1);

   // configuration registers
   logic [mm_pkg::CFG_W-1:0] rows_ff, inner_ff, cols_ff;
   logic [DIM_W-1:0]         dim_h, dim_k, dim_w;

   // request decode
   logic              req_fire, in_store;
   logic [ADDR_W-1:0] req_addr;
   logic              wr_a, wr_b, rd_p, start;

   // compute datapath
   logic [ADDR_W-1:0]          a_addr, b_addr, p_addr, prod_waddr;
   logic [mm_pkg::ELEM_W-1:0]  a_data, b_data;
   logic [mm_pkg::ACC_W-1:0]   prod_wdata, prod_rdata;
   logic                       prod_we, seq_busy, mac_busy;
   mm_pkg::mac_ctl_type        mac_ctl;

   // read return path
   logic                          rd_pend_ff, rd_oor_ff;
   logic [mm_pkg::INDEX_W-1:0]    rd_index_ff;
   logic [mm_pkg::ACC_W-1:0]      q_value_ff [mm_pkg::RSP_Q_DEPTH];
   logic [mm_pkg::INDEX_W-1:0]    q_index_ff [mm_pkg::RSP_Q_DEPTH];
   logic [QP_W-1:0]               q_wr_ptr_ff, q_wr_ptr_in, q_rd_ptr_ff, q_rd_ptr_in;
   logic [QC_W-1:0]               q_count_ff, q_count_in;
   logic                          q_push, q_pop;
   logic [QC_W:0]                 q_load;

   // Clamp a dimension register into 1..MAX_DIM.
   function automatic logic [DIM_W-1:0] eff_dim(input logic [mm_pkg::CFG_W-1:0] v);
      logic [DIM_W-1:0] r;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (32'(v) > 32'(MAX_DIM)) begin
         r = DIM_W'(MAX_DIM);
      end else begin
         r = DIM_W'(v);
      end
      return r;
   endfunction

   assign dim_h = eff_dim(rows_ff);
   assign dim_k = eff_dim(inner_ff);
   assign dim_w = eff_dim(cols_ff);

   // Register writes; an index past the list is dropped.
   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff  <= mm_pkg::DIM_RESET;
         inner_ff <= mm_pkg::DIM_RESET;
         cols_ff  <= mm_pkg::DIM_RESET;
      end else if (csr_if.valid) begin
         case (csr_if.index)
            mm_pkg::CSR_RESULT_ROWS:  rows_ff  <= csr_if.data;
            mm_pkg::CSR_INNER_LENGTH: inner_ff <= csr_if.data;
            mm_pkg::CSR_RESULT_COLS:  cols_ff  <= csr_if.data;
            default: ;
         endcase
      end
   end

   // Hold off commands while a product is computed or the queue could overflow.
   assign q_load       = (QC_W + 1)'(q_count_ff) + (QC_W + 1)'(rd_pend_ff);
   assign req_if.ready = !seq_busy && !mac_busy &&
                         (q_load < (QC_W + 1)'(mm_pkg::RSP_Q_DEPTH));
   assign req_fire     = req_if.valid && req_if.ready;
   assign in_store     = 32'(req_if.element_index) < 32'(DEPTH);
   assign req_addr     = ADDR_W'(req_if.element_index);

   assign wr_a  = req_fire && in_store && (req_if.cmd == mm_pkg::CMD_WRITE_A);
   assign wr_b  = req_fire && in_store && (req_if.cmd == mm_pkg::CMD_WRITE_B);
   assign start = req_fire && (req_if.cmd == mm_pkg::CMD_COMPUTE);
   assign rd_p  = req_fire && (req_if.cmd == mm_pkg::CMD_READ);

   mm_ram #(.WIDTH(mm_pkg::ELEM_W), .DEPTH(DEPTH)) u_left_ram (
      .clock   (clock),
      .wr_en   (wr_a),
      .wr_addr (req_addr),
      .wr_data (req_if.element_value),
      .rd_addr (a_addr),
      .rd_data (a_data)
   );

   mm_ram #(.WIDTH(mm_pkg::ELEM_W), .DEPTH(DEPTH)) u_right_ram (
      .clock   (clock),
      .wr_en   (wr_b),
      .wr_addr (req_addr),
      .wr_data (req_if.element_value),
      .rd_addr (b_addr),
      .rd_data (b_data)
   );

   mm_ram #(.WIDTH(mm_pkg::ACC_W), .DEPTH(DEPTH)) u_product_ram (
      .clock   (clock),
      .wr_en   (prod_we),
      .wr_addr (prod_waddr),
      .wr_data (prod_wdata),
      .rd_addr (req_addr),
      .rd_data (prod_rdata)
   );

   mm_seq #(.MAX_DIM(MAX_DIM)) u_seq (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .dim_h  (dim_h),
      .dim_k  (dim_k),
      .dim_w  (dim_w),
      .a_addr (a_addr),
      .b_addr (b_addr),
      .p_addr (p_addr),
      .ctl    (mac_ctl),
      .busy   (seq_busy)
   );

   mm_mac #(.MAX_DIM(MAX_DIM)) u_mac (
      .clock   (clock),
      .reset   (reset),
      .ctl     (mac_ctl),
      .p_addr  (p_addr),
      .a_data  (a_data),
      .b_data  (b_data),
      .wr_en   (prod_we),
      .wr_addr (prod_waddr),
      .wr_data (prod_wdata),
      .busy    (mac_busy)
   );

   // Read return: the product RAM answers in the cycle after the read beat.
   assign q_push = rd_pend_ff;
   assign q_pop  = rsp_if.valid && rsp_if.ready;

   always_comb begin
      q_wr_ptr_in = q_wr_ptr_ff;
      q_rd_ptr_in = q_rd_ptr_ff;
      q_count_in  = q_count_ff;
      if (q_push) begin
         q_wr_ptr_in = (q_wr_ptr_ff == QP_W'(mm_pkg::RSP_Q_DEPTH - 1)) ?
                       '0 : q_wr_ptr_ff + QP_W'(1);
      end
      if (q_pop) begin
         q_rd_ptr_in = (q_rd_ptr_ff == QP_W'(mm_pkg::RSP_Q_DEPTH - 1)) ?
                       '0 : q_rd_ptr_ff + QP_W'(1);
      end
      if (q_push && !q_pop) begin
         q_count_in = q_count_ff + QC_W'(1);
      end else if (q_pop && !q_push) begin
         q_count_in = q_count_ff - QC_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_pend_ff  <= 1'b0;
         q_wr_ptr_ff <= '0;
         q_rd_ptr_ff <= '0;
         q_count_ff  <= '0;
      end else begin
         rd_pend_ff  <= rd_p;
         q_wr_ptr_ff <= q_wr_ptr_in;
         q_rd_ptr_ff <= q_rd_ptr_in;
         q_count_ff  <= q_count_in;
      end
      rd_oor_ff   <= !in_store;
      rd_index_ff <= req_if.element_index;
      if (q_push) begin
         // drop the RAM word for a read beyond the store
         q_value_ff[q_wr_ptr_ff] <= rd_oor_ff ? '0 : prod_rdata;
         q_index_ff[q_wr_ptr_ff] <= rd_index_ff;
      end
   end

   assign rsp_if.valid         = (q_count_ff != '0);
   assign rsp_if.product_value = q_value_ff[q_rd_ptr_ff];
   assign rsp_if.product_index = q_index_ff[q_rd_ptr_ff];

   // A read in flight always finds room in the result queue.
   `MM_ASSERT(a_queue_room, rd_pend_ff |-> (q_count_ff != QC_W'(mm_pkg::RSP_Q_DEPTH)), "result queue overflow")
   // Product write-back never overlaps a taken command.
   `MM_ASSERT(a_wb_blocks_req, prod_we |-> !req_if.ready, "command taken during product write-back")
   // A compute beat starts the sequencer on the next cycle.
   `MM_ASSERT(a_compute_starts, start |=> seq_busy, "compute did not start")

endmodule

>>> src/mm_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module mm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/mm_seq.sv
// Address sequencer: walks rows, columns and the inner dimension of a product.
// Depends on mm_pkg.
module mm_seq #(
   parameter int MAX_DIM = mm_pkg::MAX_DIM_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic [$clog2(MAX_DIM+1)-1:0]          dim_h,
   input  logic [$clog2(MAX_DIM+1)-1:0]          dim_k,
   input  logic [$clog2(MAX_DIM+1)-1:0]          dim_w,
   output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]    a_addr,
   output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]    b_addr,
   output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]    p_addr,
   output mm_pkg::mac_ctl_type                   ctl,
   output logic                                  busy
);

   localparam int DIM_W  = $clog2(MAX_DIM + 1);
   localparam int ADDR_W = $clog2(MAX_DIM * MAX_DIM);

   mm_pkg::seq_state_type state_ff, state_in;
   logic [DIM_W-1:0]  i_ff, i_in, x_ff, x_in, y_ff, y_in;
   logic [ADDR_W-1:0] a_addr_ff, a_addr_in, b_addr_ff, b_addr_in;
   logic [ADDR_W-1:0] row_base_ff, row_base_in, p_addr_ff, p_addr_in;
   logic [DIM_W-1:0]  h_last, k_last, w_last;

   assign h_last = dim_h - DIM_W'(1);
   assign k_last = dim_k - DIM_W'(1);
   assign w_last = dim_w - DIM_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mm_pkg::SEQ_IDLE;
      end else begin
         state_ff <= state_in;
      end
      i_ff        <= i_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      a_addr_ff   <= a_addr_in;
      b_addr_ff   <= b_addr_in;
      row_base_ff <= row_base_in;
      p_addr_ff   <= p_addr_in;
   end

   always_comb begin
      state_in    = state_ff;
      i_in        = i_ff;
      x_in        = x_ff;
      y_in        = y_ff;
      a_addr_in   = a_addr_ff;
      b_addr_in   = b_addr_ff;
      row_base_in = row_base_ff;
      p_addr_in   = p_addr_ff;
      ctl         = '0;
      case (state_ff)
         mm_pkg::SEQ_IDLE: begin
            if (start) begin
               state_in    = mm_pkg::SEQ_RUN;
               i_in        = '0;
               x_in        = '0;
               y_in        = '0;
               a_addr_in   = '0;
               b_addr_in   = '0;
               row_base_in = '0;
               p_addr_in   = '0;
            end
         end
         mm_pkg::SEQ_RUN: begin
            ctl.valid = 1'b1;
            ctl.first = (i_ff == '0);
            ctl.last  = (i_ff == k_last);
            if (i_ff == k_last) begin
               // end of one dot product: step to the next product element
               i_in      = '0;
               p_addr_in = p_addr_ff + ADDR_W'(1);
               if (x_ff == w_last) begin
                  x_in        = '0;
                  y_in        = y_ff + DIM_W'(1);
                  row_base_in = row_base_ff + ADDR_W'(dim_k);
                  a_addr_in   = row_base_ff + ADDR_W'(dim_k);
                  b_addr_in   = '0;
                  if (y_ff == h_last) begin
                     state_in = mm_pkg::SEQ_IDLE;
                  end
               end else begin
                  x_in      = x_ff + DIM_W'(1);
                  a_addr_in = row_base_ff;
                  b_addr_in = ADDR_W'(x_ff) + ADDR_W'(1);
               end
            end else begin
               i_in      = i_ff + DIM_W'(1);
               a_addr_in = a_addr_ff + ADDR_W'(1);
               b_addr_in = b_addr_ff + ADDR_W'(dim_w);
            end
         end
         default: begin
            state_in = mm_pkg::SEQ_IDLE;
         end
      endcase
   end

   assign a_addr = a_addr_ff;
   assign b_addr = b_addr_ff;
   assign p_addr = p_addr_ff;
   assign busy   = (state_ff == mm_pkg::SEQ_RUN);

endmodule

>>> src/mm_mac.sv
// Multiply-accumulate pipeline: multiply, accumulate, write back one product.
// Depends on mm_pkg.
module mm_mac #(
   parameter int MAX_DIM = mm_pkg::MAX_DIM_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  mm_pkg::mac_ctl_type                  ctl,
   input  logic [$clog2(MAX_DIM*MAX_DIM)-1:0]   p_addr,
   input  logic [mm_pkg::ELEM_W-1:0]            a_data,
   input  logic [mm_pkg::ELEM_W-1:0]            b_data,
   output logic                                 wr_en,
   output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]   wr_addr,
   output logic [mm_pkg::ACC_W-1:0]             wr_data,
   output logic                                 busy
);

   localparam int ADDR_W = $clog2(MAX_DIM * MAX_DIM);

   mm_pkg::mac_ctl_type st1_ctl_ff, st2_ctl_ff;
   logic [ADDR_W-1:0]   st1_addr_ff, st2_addr_ff, wr_addr_ff;
   logic signed [mm_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic [mm_pkg::ACC_W-1:0] acc_ff, acc_in, prod_ext;
   logic                wr_en_ff;

   assign prod_in  = $signed(a_data) * $signed(b_data);
   assign prod_ext = {{(mm_pkg::ACC_W - mm_pkg::PROD_W){prod_ff[mm_pkg::PROD_W-1]}}, prod_ff};
   assign acc_in   = st2_ctl_ff.first ? prod_ext : acc_ff + prod_ext;

   always_ff @(posedge clock) begin
      if (reset) begin
         st1_ctl_ff <= '0;
         st2_ctl_ff <= '0;
         wr_en_ff   <= 1'b0;
      end else begin
         st1_ctl_ff <= ctl;
         st2_ctl_ff <= st1_ctl_ff;
         wr_en_ff   <= st2_ctl_ff.valid && st2_ctl_ff.last;
      end
      st1_addr_ff <= p_addr;
      st2_addr_ff <= st1_addr_ff;
      wr_addr_ff  <= st2_addr_ff;
      prod_ff     <= prod_in;
      if (st2_ctl_ff.valid) begin
         acc_ff <= acc_in;
      end
   end

   assign wr_en   = wr_en_ff;
   assign wr_addr = wr_addr_ff;
   assign wr_data = acc_ff;
   assign busy    = st1_ctl_ff.valid || st2_ctl_ff.valid || wr_en_ff;

endmodule

>>> bench/matrix_multiply_top_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for matrix_multiply_top: loads A and B, multiplies, reads back.
// Depends on mm_pkg, the three channel interfaces and the block sources in src.
module matrix_multiply_top_tb;
   import mm_pkg::*;

   localparam int STORE_DEPTH = MAX_DIM_DEFAULT * MAX_DIM_DEFAULT;
   localparam int ITEM_TARGET = 1400;
   localparam int CYCLE_LIMIT = 600000;
   localparam int MAX_GAP     = 13;
   localparam int TAIL_CYCLES = 20;
   // Register slot with no register behind it; writes there must change nothing.
   localparam logic [CSR_ADDR_W-1:0] CSR_SPARE = 2'd3;

   typedef struct {
      logic signed [ACC_W-1:0] value;
      logic [INDEX_W-1:0]      index;
   } product_beat_type;

   // Tracks the dimension registers and the three stores, and queues the
   // product elements that read beats must return.
   class product_scoreboard;
      logic [CFG_W-1:0]        rows_reg, inner_reg, cols_reg;
      logic signed [ELEM_W-1:0] left_mem [STORE_DEPTH];
      logic signed [ELEM_W-1:0] right_mem [STORE_DEPTH];
      logic signed [ACC_W-1:0]  product_mem [STORE_DEPTH];
      product_beat_type        expected_products[$];
      int                      mismatches;
      int                      checked;

      function new();
         rows_reg   = DIM_RESET;
         inner_reg  = DIM_RESET;
         cols_reg   = DIM_RESET;
         mismatches = 0;
         checked    = 0;
         for (int i = 0; i < STORE_DEPTH; i++) begin
            left_mem[i]    = '0;
            right_mem[i]   = '0;
            product_mem[i] = '0;
         end
      endfunction

      // Zero counts as one, anything past the largest dimension as the largest dimension.
      function int effective_dim(logic [CFG_W-1:0] raw);
         if (raw == 0)
            return 1;
         if (raw > MAX_DIM_DEFAULT)
            return MAX_DIM_DEFAULT;
         return int'(raw);
      endfunction

      function void note_register(logic [CSR_ADDR_W-1:0] index, logic [CFG_W-1:0] data);
         case (index)
            CSR_RESULT_ROWS:  rows_reg  = data;
            CSR_INNER_LENGTH: inner_reg = data;
            CSR_RESULT_COLS:  cols_reg  = data;
            default: ;
         endcase
      endfunction

      function void multiply_all();
         int     h, k, w;
         longint acc;
         h = effective_dim(rows_reg);
         k = effective_dim(inner_reg);
         w = effective_dim(cols_reg);
         for (int y = 0; y < h; y++) begin
            for (int x = 0; x < w; x++) begin
               acc = 0;
               for (int i = 0; i < k; i++)
                  acc += longint'(left_mem[i + y * k]) * longint'(right_mem[x + i * w]);
               product_mem[y * w + x] = acc[ACC_W-1:0];
            end
         end
      endfunction

      function void note_command(cmd_type cmd, logic [INDEX_W-1:0] index,
                                 logic signed [ELEM_W-1:0] value);
         product_beat_type beat;
         case (cmd)
            CMD_WRITE_A: left_mem[index]  = value;
            CMD_WRITE_B: right_mem[index] = value;
            CMD_COMPUTE: multiply_all();
            default: begin
               beat.value = product_mem[index];
               beat.index = index;
               expected_products.push_back(beat);
            end
         endcase
      endfunction

      task report_mismatch(string msg);
         mismatches++;
         $display("ERROR @%0t: %s", $realtime, msg);
      endtask

      task check_product(logic signed [ACC_W-1:0] value, logic [INDEX_W-1:0] index);
         product_beat_type want;
         if (expected_products.size() == 0) begin
            report_mismatch($sformatf("result with no read pending: index %0d value %0d",
                                      index, value));
            return;
         end
         want = expected_products.pop_front();
         checked++;
         if (index !== want.index)
            report_mismatch($sformatf("product_index %0d, want %0d", index, want.index));
         if (value !== want.value)
            report_mismatch($sformatf("product_value %0d at index %0d, want %0d",
                                      value, want.index, want.value));
      endtask
   endclass

   logic clock = 1'b0;
   logic reset;

   mm_req_if req_if ();
   mm_rsp_if rsp_if ();
   mm_csr_if csr_if ();

   matrix_multiply_top uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   product_scoreboard sb;

   // Which store entries hold defined data; the stimulus never reads past these.
   bit     a_loaded [STORE_DEPTH];
   bit     b_loaded [STORE_DEPTH];
   bit     p_loaded [STORE_DEPTH];
   int     cur_rows, cur_inner, cur_cols;
   int     items_sent, computes_sent, csr_writes;
   int     busy_cycles;
   bit     sender_brisk;
   longint cycle_count = 0;

   // 8 ns clock, high then low.
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Watchdog: end the run as failed if it is still going at the cycle limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d reads still pending",
                  cycle_count, sb.expected_products.size());
         $display("matrix_multiply_top_tb NOT OK");
         $finish;
      end
   end

   // Sample every accepted beat at the rising edge. Note the command before
   // checking results: a read taken at this edge cannot already have answered.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_if.valid && csr_if.ready)
            sb.note_register(csr_if.index, csr_if.data);
         if (req_if.valid && req_if.ready)
            sb.note_command(cmd_type'(req_if.cmd), req_if.element_index,
                            req_if.element_value);
         if (rsp_if.valid && rsp_if.ready)
            sb.check_product(rsp_if.product_value, rsp_if.product_index);
      end
   end

   // Result sink: draw a stall for each result, sometimes run a stretch with none.
   initial begin : result_sink
      int stall;
      int run_left;
      bit brisk;
      rsp_if.ready = 1'b0;
      run_left     = 0;
      brisk        = 1'b0;
      forever begin
         if (run_left == 0) begin
            brisk    = ($urandom_range(0, 3) == 0);
            run_left = $urandom_range(10, 40);
         end
         run_left--;
         stall = brisk ? 0 : $urandom_range(0, MAX_GAP);
         if (stall > 0) begin
            @(negedge clock);
            rsp_if.ready <= 1'b0;
            repeat (stall - 1) @(negedge clock);
         end
         @(negedge clock);
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!rsp_if.valid);
      end
   end

   function automatic logic signed [ELEM_W-1:0] random_value();
      case ($urandom_range(0, 7))
         0: return 16'sh8000;
         1: return 16'sh7FFF;
         2: return ELEM_W'($urandom_range(0, 511) - 256);
         3: return '0;
         default: return ELEM_W'($urandom);
      endcase
   endfunction

   // Raw register value: mostly small, now and then full size, zero or oversized.
   function automatic logic [CFG_W-1:0] random_dim();
      case ($urandom_range(0, 19))
         16: return '0;
         17: return CFG_W'($urandom_range(17, 31));
         18: return CFG_W'($urandom_range(5, 16));
         19: return CFG_W'(16);
         default: return CFG_W'($urandom_range(1, 4));
      endcase
   endfunction

   function automatic bit operands_ready();
      for (int i = 0; i < cur_rows * cur_inner; i++)
         if (!a_loaded[i])
            return 1'b0;
      for (int i = 0; i < cur_inner * cur_cols; i++)
         if (!b_loaded[i])
            return 1'b0;
      return 1'b1;
   endfunction

   // Any product address that some multiply has filled, stale ones included.
   function automatic logic [INDEX_W-1:0] pick_stored_product();
      logic [INDEX_W-1:0] index;
      index = INDEX_W'($urandom);
      while (!p_loaded[index])
         index = INDEX_W'($urandom);
      return index;
   endfunction

   // Drive one command beat after a random gap and hold it until accepted.
   // Leave valid high afterwards so back-to-back beats need no re-raise.
   task automatic send_command(input cmd_type cmd, input logic [INDEX_W-1:0] index,
                               input logic signed [ELEM_W-1:0] value);
      int gap;
      gap = sender_brisk ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         @(negedge clock);
         req_if.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_if.valid         <= 1'b1;
      req_if.cmd           <= cmd;
      req_if.element_index <= index;
      req_if.element_value <= value;
      do @(posedge clock); while (!req_if.ready);
      items_sent++;
      case (cmd)
         CMD_WRITE_A: a_loaded[index] = 1'b1;
         CMD_WRITE_B: b_loaded[index] = 1'b1;
         CMD_COMPUTE: begin
            for (int i = 0; i < cur_rows * cur_cols; i++)
               p_loaded[i] = 1'b1;
            computes_sent++;
            busy_cycles = cur_rows * cur_cols * cur_inner + 8;
         end
         default: ;
      endcase
   endtask

   // Drop valid and hold off until every pending read has answered.
   task automatic wait_for_results();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (sb.expected_products.size() != 0)
         @(posedge clock);
   endtask

   // A multiply gives no result, so after the last read also let it finish.
   task automatic settle_block();
      wait_for_results();
      repeat (busy_cycles) @(posedge clock);
      busy_cycles = 0;
   endtask

   task automatic write_register(input logic [CSR_ADDR_W-1:0] index,
                                 input logic [CFG_W-1:0] data);
      @(negedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= index;
      csr_if.data  <= data;
      do @(posedge clock); while (!csr_if.ready);
      csr_writes++;
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   // Wait for idle, then write all three dimensions in a random order, sometimes followed by a spare-slot write.
   task automatic configure(input logic [CFG_W-1:0] raw_rows, raw_inner, raw_cols);
      int order [3];
      int pick, tmp;
      settle_block();
      order = '{0, 1, 2};
      for (int i = 2; i > 0; i--) begin
         pick        = $urandom_range(0, i);
         tmp         = order[i];
         order[i]    = order[pick];
         order[pick] = tmp;
      end
      foreach (order[i]) begin
         case (order[i])
            0: write_register(CSR_RESULT_ROWS, raw_rows);
            1: write_register(CSR_INNER_LENGTH, raw_inner);
            default: write_register(CSR_RESULT_COLS, raw_cols);
         endcase
      end
      if ($urandom_range(0, 2) == 0)
         write_register(CSR_SPARE, CFG_W'($urandom));
      cur_rows  = sb.effective_dim(raw_rows);
      cur_inner = sb.effective_dim(raw_inner);
      cur_cols  = sb.effective_dim(raw_cols);
   endtask

   // Stray beat: a write anywhere, a read of any filled product address,
   // or an early multiply when the operands happen to be defined already.
   task automatic send_noise();
      case ($urandom_range(0, 3))
         0: send_command(CMD_WRITE_A, INDEX_W'($urandom), random_value());
         1: send_command(CMD_WRITE_B, INDEX_W'($urandom), random_value());
         2: send_command(CMD_READ, pick_stored_product(), random_value());
         default: begin
            if (operands_ready())
               send_command(CMD_COMPUTE, INDEX_W'($urandom), random_value());
            else
               send_command(CMD_WRITE_B, INDEX_W'($urandom), random_value());
         end
      endcase
   endtask

   // One well-formed job: set dimensions, load A and B in shuffled order,
   // multiply, read back. Sprinkle stray beats and pauses throughout.
   task automatic run_phase(input logic [CFG_W-1:0] raw_rows, raw_inner, raw_cols,
                            input bit full_read);
      int                 loads[$];
      int                 pick, tmp, reads;
      logic [INDEX_W-1:0] index;
      configure(raw_rows, raw_inner, raw_cols);
      sender_brisk = ($urandom_range(0, 4) == 0);
      for (int i = 0; i < cur_rows * cur_inner; i++)
         loads.push_back(i);
      for (int i = 0; i < cur_inner * cur_cols; i++)
         loads.push_back(STORE_DEPTH + i);
      for (int i = loads.size() - 1; i > 0; i--) begin
         pick        = $urandom_range(0, i);
         tmp         = loads[i];
         loads[i]    = loads[pick];
         loads[pick] = tmp;
      end
      foreach (loads[i]) begin
         if (loads[i] < STORE_DEPTH)
            send_command(CMD_WRITE_A, INDEX_W'(loads[i]), random_value());
         else
            send_command(CMD_WRITE_B, INDEX_W'(loads[i] - STORE_DEPTH), random_value());
         if ($urandom_range(0, 11) == 0)
            send_noise();
      end
      send_command(CMD_COMPUTE, INDEX_W'($urandom), random_value());
      reads = full_read ? cur_rows * cur_cols : $urandom_range(1, 12);
      for (int i = 0; i < reads; i++) begin
         if (full_read)
            index = INDEX_W'(i);
         else if ($urandom_range(0, 3) != 0)
            index = INDEX_W'($urandom_range(0, cur_rows * cur_cols - 1));
         else
            index = pick_stored_product();
         send_command(CMD_READ, index, random_value());
         if ($urandom_range(0, 9) == 0)
            send_noise();
         if ($urandom_range(0, 29) == 0)
            wait_for_results();
      end
   endtask

   initial begin
      sb = new();
      reset                = 1'b1;
      req_if.valid         = 1'b0;
      req_if.cmd           = CMD_WRITE_A;
      req_if.element_index = '0;
      req_if.element_value = '0;
      csr_if.valid         = 1'b0;
      csr_if.index         = CSR_RESULT_ROWS;
      csr_if.data          = DIM_RESET;
      cur_rows             = MAX_DIM_DEFAULT;
      cur_inner            = MAX_DIM_DEFAULT;
      cur_cols             = MAX_DIM_DEFAULT;
      items_sent           = 0;
      computes_sent        = 0;
      csr_writes           = 0;
      busy_cycles          = 0;
      sender_brisk         = 1'b0;

      repeat (11) @(negedge clock);
      reset <= 1'b0;

      // Directed: 2x2x2 with the extreme element values, so the sums reach
      // the largest products; park patterns at the top address outside the
      // current shape; multiply; read every element, one of them twice.
      configure(CFG_W'(2), CFG_W'(2), CFG_W'(2));
      send_command(CMD_WRITE_A, 8'd0, 16'sh7FFF);
      send_command(CMD_WRITE_A, 8'd1, 16'sh8000);
      send_command(CMD_WRITE_A, 8'd2, 16'shFFFF);
      send_command(CMD_WRITE_A, 8'd3, 16'sh0001);
      send_command(CMD_WRITE_B, 8'd0, 16'sh8000);
      send_command(CMD_WRITE_B, 8'd1, 16'sh7FFF);
      send_command(CMD_WRITE_B, 8'd2, 16'sh8000);
      send_command(CMD_WRITE_B, 8'd3, 16'sh0000);
      send_command(CMD_WRITE_A, 8'd255, 16'sh5555);
      send_command(CMD_WRITE_B, 8'd255, 16'shAAAA);
      send_command(CMD_COMPUTE, 8'hFF, 16'sh7FFF);
      send_command(CMD_READ, 8'd3, 16'sh8000);
      send_command(CMD_READ, 8'd0, '0);
      send_command(CMD_READ, 8'd1, '0);
      send_command(CMD_READ, 8'd2, '0);
      send_command(CMD_READ, 8'd3, 16'shFFFF);

      // Shape extremes: full-size result with inner length one, read in full; full size on
      // every axis, rows and columns through oversized register values; all zeros.
      run_phase(CFG_W'(16), CFG_W'(1), CFG_W'(16), 1'b1);
      run_phase(CFG_W'(31), CFG_W'(16), CFG_W'(17), 1'b0);
      run_phase(CFG_W'(0), CFG_W'(0), CFG_W'(0), 1'b0);

      // Random jobs until the item budget is spent.
      while (items_sent < ITEM_TARGET)
         run_phase(random_dim(), random_dim(), random_dim(), 1'b0);

      settle_block();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.expected_products.size() != 0)
         sb.report_mismatch($sformatf("%0d reads never answered",
                                      sb.expected_products.size()));

      $display("Sent %0d command beats including %0d multiplies, %0d register writes;",
               items_sent, computes_sent, csr_writes);
      $display("checked %0d product reads, %0d mismatches.", sb.checked, sb.mismatches);
      if (sb.mismatches == 0)
         $display("matrix_multiply_top_tb OK");
      else
         $display("matrix_multiply_top_tb NOT OK");
      $finish;
   end

endmodule
